/* rtl/adaptive_window_flow_control_defines.svh */
// assertion helpers, sampled on clk and held off while arst_n is low
`ifndef ADAPTIVE_WINDOW_FLOW_CONTROL_DEFINES_SVH
`define ADAPTIVE_WINDOW_FLOW_CONTROL_DEFINES_SVH

// consequent checked in the same cycle
`define AWFC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent checked in the next cycle
`define AWFC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/awfc_pkg.sv */
package awfc_pkg;

	// field widths
	localparam int CmdW     = 2;
	localparam int AmountW  = 24;
	localparam int CfgIdxW  = 3;
	localparam int CfgDataW = 16;
	localparam int PktKibW  = 11;
	localparam int WinKibW  = 16;
	localparam int TimeW    = 16;
	localparam int PacketW  = 21;
	localparam int WordW    = 32;
	localparam int AckW     = 40;
	localparam int KibShift = 10;

	// serial arithmetic: product register and step counts
	localparam int ProdW    = AckW + TimeW;
	localparam int MulSteps = TimeW;
	localparam int DivSteps = ProdW;
	localparam int CntW     = $clog2(DivSteps);

	typedef enum logic [CmdW-1:0] {
		CMD_SENT,
		CMD_ACKED,
		CMD_TICK,
		CMD_POLL
	} cmd_t;

	// register indexes
	localparam logic [CfgIdxW-1:0] REG_MIN_PACKET = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_MAX_PACKET = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_MIN_WINDOW = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_WINDOW_TIME = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_FLUSH_TIME = 3'd4;

	// register values after reset
	localparam logic [PktKibW-1:0] MIN_PACKET_KIB_RST = 11'd4;
	localparam logic [PktKibW-1:0] MAX_PACKET_KIB_RST = 11'd64;
	localparam logic [WinKibW-1:0] MIN_WINDOW_KIB_RST = 16'd256;
	localparam logic [TimeW-1:0]   WINDOW_TIME_RST    = 16'd2000;
	localparam logic [TimeW-1:0]   FLUSH_TIME_RST     = 16'd500;

	localparam logic [PacketW-1:0] PACKET_RST = {MIN_PACKET_KIB_RST, {KibShift{1'b0}}};
	localparam logic [WordW-1:0]   WINDOW_RST =
		{{(WordW - WinKibW - KibShift){1'b0}}, MIN_WINDOW_KIB_RST, {KibShift{1'b0}}};

	// timing thresholds in ms
	localparam logic [WordW-1:0] MEAS_MIN_MS = 32'd500;
	localparam logic [WordW-1:0] POLL_MIN_MS = 32'd2000;
	localparam logic [TimeW-1:0] MS_PER_SEC  = 16'd1000;

	typedef enum logic [2:0] {
		S_IDLE,
		S_UPDATE,
		S_DECIDE,
		S_MEAS,
		S_FINISH
	} top_state_t;

	typedef enum logic [2:0] {
		M_IDLE,
		M_MUL,
		M_DIV,
		M_POST,
		M_DONE
	} meas_state_t;

	typedef enum logic [1:0] {
		PH_RATE,
		PH_PACKET,
		PH_WINDOW
	} meas_phase_t;

	typedef struct packed {
		logic [PktKibW-1:0] min_packet_kib;
		logic [PktKibW-1:0] max_packet_kib;
		logic [WinKibW-1:0] min_window_kib;
		logic [TimeW-1:0]   window_time_ms;
		logic [TimeW-1:0]   flush_time_ms;
	} cfg_regs_t;

	typedef struct packed {
		logic             start;
		logic [AckW-1:0]  acked;
		logic [WordW-1:0] elapsed;
	} meas_req_t;

	typedef struct packed {
		logic               done;
		logic               upd;
		logic [WordW-1:0]   rate;
		logic [PacketW-1:0] packet;
		logic [WordW-1:0]   window;
	} meas_rsp_t;

endpackage

/* rtl/awfc_if.sv */
interface awfc_evt_if;
	logic                         valid;
	logic                         ready;
	logic [awfc_pkg::CmdW-1:0]    cmd;
	logic [awfc_pkg::AmountW-1:0] amount;

	modport source (output valid, output cmd, output amount, input ready);
	modport sink (input valid, input cmd, input amount, output ready);
endinterface

interface awfc_res_if;
	logic                         valid;
	logic                         ready;
	logic                         send_enabled;
	logic                         enable_changed;
	logic [awfc_pkg::PacketW-1:0] packet_bytes;
	logic [awfc_pkg::WordW-1:0]   window_bytes;
	logic [awfc_pkg::WordW-1:0]   rate_bytes_per_sec;

	modport source (output valid, output send_enabled, output enable_changed,
		output packet_bytes, output window_bytes, output rate_bytes_per_sec, input ready);
	modport sink (input valid, input send_enabled, input enable_changed,
		input packet_bytes, input window_bytes, input rate_bytes_per_sec, output ready);
endinterface

interface awfc_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [awfc_pkg::CfgIdxW-1:0]  index;
	logic [awfc_pkg::CfgDataW-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

/* rtl/adaptive_window_flow_control.sv */
// an accepted word passes the update, decide and finish states, with a measure state between
//   decide and finish when it triggers a measurement; no new word is taken until its result
//   word is registered; a measurement runs awfc_meas with a 16-step shift-add multiply and a
//   56-step restoring divide for the rate, then for packet and window unless the rate is zero
// reset: registers to their defaults, counters and rate zero, packet 4096, window 262144,
//   sending enabled, no result word pending
`include "adaptive_window_flow_control_defines.svh"

module adaptive_window_flow_control (
	input  logic      clk,
	input  logic      arst_n,
	awfc_evt_if.sink  evt,
	awfc_res_if.source res,
	awfc_cfg_if.sink  cfg
);

	localparam int WordW   = awfc_pkg::WordW;
	localparam int AckW    = awfc_pkg::AckW;
	localparam int AmountW = awfc_pkg::AmountW;
	localparam int PktW    = awfc_pkg::PacketW;

	// control
	awfc_pkg::top_state_t state_q, state_d;
	logic evt_ready;
	logic upd_en, decide_en, meas_wait_en, load_out;
	logic meas_start;
	logic out_free;

	// configuration registers
	awfc_pkg::cfg_regs_t cfg_q;

	// flow state
	logic [WordW-1:0] unacked_q;
	logic [AckW-1:0]  acked_q;
	logic [WordW-1:0] elapsed_q;
	logic [WordW-1:0] rate_q;
	logic [PktW-1:0]  packet_q;
	logic [WordW-1:0] window_q;
	logic             enabled_q;

	// latched event word
	awfc_pkg::cmd_t     cmd_q;
	logic [AmountW-1:0] amount_q;
	logic               changed_q;

	// output register
	logic             res_valid_q;
	logic             res_enabled_q;
	logic             res_changed_q;
	logic [PktW-1:0]  res_packet_q;
	logic [WordW-1:0] res_window_q;
	logic [WordW-1:0] res_rate_q;

	// measurement unit
	awfc_pkg::meas_req_t meas_req;
	awfc_pkg::meas_rsp_t meas_rsp;

	// counter arithmetic, all saturating
	logic [WordW:0]   unacked_sum;
	logic [WordW-1:0] unacked_add;
	logic [WordW-1:0] unacked_sub;
	logic [AckW:0]    acked_sum;
	logic [AckW-1:0]  acked_add;
	logic [WordW-1:0] elapsed_inc;

	// decisions taken in the cycle after the counters settle
	logic stop_hit, resume_hit, poll_hit, meas_want, meas_ok;

	assign unacked_sum = {1'b0, unacked_q} + (WordW + 1)'(amount_q);
	assign unacked_add = unacked_sum[WordW] ? '1 : unacked_sum[WordW-1:0];
	assign unacked_sub = (unacked_q > WordW'(amount_q)) ? unacked_q - WordW'(amount_q) : '0;
	assign acked_sum   = {1'b0, acked_q} + (AckW + 1)'(amount_q);
	assign acked_add   = acked_sum[AckW] ? '1 : acked_sum[AckW-1:0];
	assign elapsed_inc = (&elapsed_q) ? elapsed_q : elapsed_q + 1'b1;

	// stop at the window, resume at half the window or below
	assign stop_hit   = (cmd_q == awfc_pkg::CMD_SENT) && enabled_q && (unacked_q >= window_q);
	assign resume_hit = (cmd_q == awfc_pkg::CMD_ACKED) && !enabled_q
		&& (unacked_q <= {1'b0, window_q[WordW-1:1]});
	assign poll_hit   = (cmd_q == awfc_pkg::CMD_POLL) && (elapsed_q > awfc_pkg::POLL_MIN_MS);
	assign meas_want  = stop_hit || poll_hit;
	// too early since the last measurement: request dropped
	assign meas_ok    = elapsed_q >= awfc_pkg::MEAS_MIN_MS;

	assign out_free = !res_valid_q || res.ready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			awfc_pkg::S_IDLE: begin
				if (evt.valid) state_d = awfc_pkg::S_UPDATE;
			end
			awfc_pkg::S_UPDATE: state_d = awfc_pkg::S_DECIDE;
			awfc_pkg::S_DECIDE: begin
				state_d = (meas_want && meas_ok) ? awfc_pkg::S_MEAS : awfc_pkg::S_FINISH;
			end
			awfc_pkg::S_MEAS: begin
				if (meas_rsp.done) state_d = awfc_pkg::S_FINISH;
			end
			awfc_pkg::S_FINISH: begin
				if (out_free) state_d = awfc_pkg::S_IDLE;
			end
			default: state_d = awfc_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		evt_ready    = 1'b0;
		upd_en       = 1'b0;
		decide_en    = 1'b0;
		meas_start   = 1'b0;
		meas_wait_en = 1'b0;
		load_out     = 1'b0;
		case (state_q)
			awfc_pkg::S_IDLE:   evt_ready = 1'b1;
			awfc_pkg::S_UPDATE: upd_en    = 1'b1;
			awfc_pkg::S_DECIDE: begin
				decide_en  = 1'b1;
				meas_start = meas_want && meas_ok;
			end
			awfc_pkg::S_MEAS:   meas_wait_en = 1'b1;
			awfc_pkg::S_FINISH: load_out     = out_free;
			default: ;
		endcase
	end

	assign evt.ready = evt_ready;
	// registers accept a write at any time
	assign cfg.ready = 1'b1;

	// measurement takes a snapshot of the totals as they are cleared
	assign meas_req.start   = meas_start;
	assign meas_req.acked   = acked_q;
	assign meas_req.elapsed = elapsed_q;

	awfc_meas u_meas (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (meas_req),
		.cfg_regs (cfg_q),
		.rsp      (meas_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q              <= awfc_pkg::S_IDLE;
			res_valid_q          <= 1'b0;
			cfg_q.min_packet_kib <= awfc_pkg::MIN_PACKET_KIB_RST;
			cfg_q.max_packet_kib <= awfc_pkg::MAX_PACKET_KIB_RST;
			cfg_q.min_window_kib <= awfc_pkg::MIN_WINDOW_KIB_RST;
			cfg_q.window_time_ms <= awfc_pkg::WINDOW_TIME_RST;
			cfg_q.flush_time_ms  <= awfc_pkg::FLUSH_TIME_RST;
			unacked_q            <= '0;
			acked_q              <= '0;
			elapsed_q            <= '0;
			rate_q               <= '0;
			packet_q             <= awfc_pkg::PACKET_RST;
			window_q             <= awfc_pkg::WINDOW_RST;
			enabled_q            <= 1'b1;
		end else begin
			state_q <= state_d;

			// register writes, indexes beyond the list dropped
			if (cfg.valid) begin
				case (cfg.index)
					awfc_pkg::REG_MIN_PACKET:
						cfg_q.min_packet_kib <= cfg.data[awfc_pkg::PktKibW-1:0];
					awfc_pkg::REG_MAX_PACKET:
						cfg_q.max_packet_kib <= cfg.data[awfc_pkg::PktKibW-1:0];
					awfc_pkg::REG_MIN_WINDOW:
						cfg_q.min_window_kib <= cfg.data[awfc_pkg::WinKibW-1:0];
					awfc_pkg::REG_WINDOW_TIME:
						cfg_q.window_time_ms <= cfg.data[awfc_pkg::TimeW-1:0];
					awfc_pkg::REG_FLUSH_TIME:
						cfg_q.flush_time_ms  <= cfg.data[awfc_pkg::TimeW-1:0];
					default: ;
				endcase
			end

			if (upd_en) begin
				case (cmd_q)
					awfc_pkg::CMD_SENT:  unacked_q <= unacked_add;
					awfc_pkg::CMD_ACKED: begin
						unacked_q <= unacked_sub;
						acked_q   <= acked_add;
					end
					awfc_pkg::CMD_TICK:  elapsed_q <= elapsed_inc;
					default: ;
				endcase
			end

			if (decide_en) begin
				if (stop_hit) enabled_q <= 1'b0;
				if (resume_hit) enabled_q <= 1'b1;
				if (meas_start) begin
					acked_q   <= '0;
					elapsed_q <= '0;
				end
			end

			// a zero rate is recorded but leaves packet and window alone
			if (meas_wait_en && meas_rsp.done) begin
				rate_q <= meas_rsp.rate;
				if (meas_rsp.upd) begin
					packet_q <= meas_rsp.packet;
					window_q <= meas_rsp.window;
				end
			end

			if (load_out) res_valid_q <= 1'b1;
			else if (res.ready) res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (evt.valid && evt_ready) begin
			cmd_q    <= awfc_pkg::cmd_t'(evt.cmd);
			amount_q <= evt.amount;
		end
		if (decide_en) changed_q <= stop_hit || resume_hit;
		if (load_out) begin
			res_enabled_q <= enabled_q;
			res_changed_q <= changed_q;
			res_packet_q  <= packet_q;
			res_window_q  <= window_q;
			res_rate_q    <= rate_q;
		end
	end

	assign res.valid              = res_valid_q;
	assign res.send_enabled       = res_enabled_q;
	assign res.enable_changed     = res_changed_q;
	assign res.packet_bytes       = res_packet_q;
	assign res.window_bytes       = res_window_q;
	assign res.rate_bytes_per_sec = res_rate_q;

	`AWFC_ASSERT_NEXT(a_accept_starts_update, evt.valid && evt.ready, state_q == awfc_pkg::S_UPDATE, "accepted word did not start an update")
	`AWFC_ASSERT_NOW(a_meas_done_while_waiting, meas_rsp.done, state_q == awfc_pkg::S_MEAS, "measurement finished while not awaited")
	`AWFC_ASSERT_NEXT(a_meas_clears_totals, meas_req.start, acked_q == '0 && elapsed_q == '0, "measurement start did not clear totals")

endmodule

/* rtl/awfc_meas.sv */
module awfc_meas (
	input  logic                clk,
	input  logic                arst_n,
	input  awfc_pkg::meas_req_t req,
	input  awfc_pkg::cfg_regs_t cfg_regs,
	output awfc_pkg::meas_rsp_t rsp
);

	localparam int ProdW = awfc_pkg::ProdW;
	localparam int AckW  = awfc_pkg::AckW;
	localparam int WordW = awfc_pkg::WordW;
	localparam int TimeW = awfc_pkg::TimeW;
	localparam int PktW  = awfc_pkg::PacketW;
	localparam int CntW  = awfc_pkg::CntW;
	localparam int KibSh = awfc_pkg::KibShift;

	awfc_pkg::meas_state_t state_q, state_d;
	awfc_pkg::meas_phase_t phase_q;
	logic [CntW-1:0]  cnt_q;

	logic [AckW-1:0]  mcand_q;
	logic [TimeW-1:0] mplier_q;
	logic [ProdW-1:0] prod_q;
	logic [WordW-1:0] rem_q;
	logic [WordW-1:0] divisor_q;
	logic [WordW-1:0] rate_q;
	logic [PktW-1:0]  packet_q;
	logic [WordW-1:0] window_q;
	logic             upd_q;

	logic             start_en, mul_en, div_en, post_en, done_en;
	logic             mul_last, div_last;
	logic [ProdW-1:0] mul_sum;
	logic [WordW:0]   rem_sh;
	logic             rem_ge;
	logic [WordW-1:0] rem_next;
	logic [WordW-1:0] quo_sat;
	logic             rate_zero;
	logic [PktW-1:0]  pkt_hi, pkt_lo, pkt_top, pkt_clamp;
	logic [WordW-1:0] win_min, win_clamp;

	assign mul_last = cnt_q == CntW'(awfc_pkg::MulSteps - 1);
	assign div_last = cnt_q == CntW'(awfc_pkg::DivSteps - 1);

	// one multiplier bit per step, msb first
	assign mul_sum = {prod_q[ProdW-2:0], 1'b0}
		+ (mplier_q[TimeW-1] ? {{(ProdW - AckW){1'b0}}, mcand_q} : '0);

	// restoring divide, one quotient bit per step shifted into prod_q
	assign rem_sh   = {rem_q, prod_q[ProdW-1]};
	assign rem_ge   = rem_sh >= {1'b0, divisor_q};
	assign rem_next = rem_ge ? WordW'(rem_sh - {1'b0, divisor_q}) : rem_sh[WordW-1:0];

	assign quo_sat   = (|prod_q[ProdW-1:WordW]) ? '1 : prod_q[WordW-1:0];
	assign rate_zero = quo_sat == '0;

	// packet clamp: upper bound first, lower bound wins when crossed
	assign pkt_hi    = {cfg_regs.max_packet_kib, {KibSh{1'b0}}};
	assign pkt_lo    = {cfg_regs.min_packet_kib, {KibSh{1'b0}}};
	assign pkt_top   = (prod_q > {{(ProdW - PktW){1'b0}}, pkt_hi}) ? pkt_hi : prod_q[PktW-1:0];
	assign pkt_clamp = (pkt_top < pkt_lo) ? pkt_lo : pkt_top;

	assign win_min   = {{(WordW - awfc_pkg::WinKibW - KibSh){1'b0}},
		cfg_regs.min_window_kib, {KibSh{1'b0}}};
	assign win_clamp = (quo_sat < win_min) ? win_min : quo_sat;

	always_comb begin
		state_d = state_q;
		case (state_q)
			awfc_pkg::M_IDLE: begin
				if (req.start) state_d = awfc_pkg::M_MUL;
			end
			awfc_pkg::M_MUL: begin
				if (mul_last) state_d = awfc_pkg::M_DIV;
			end
			awfc_pkg::M_DIV: begin
				if (div_last) state_d = awfc_pkg::M_POST;
			end
			awfc_pkg::M_POST: begin
				case (phase_q)
					awfc_pkg::PH_RATE:   state_d = rate_zero ? awfc_pkg::M_DONE : awfc_pkg::M_MUL;
					awfc_pkg::PH_PACKET: state_d = awfc_pkg::M_MUL;
					default:             state_d = awfc_pkg::M_DONE;
				endcase
			end
			awfc_pkg::M_DONE: state_d = awfc_pkg::M_IDLE;
			default:          state_d = awfc_pkg::M_IDLE;
		endcase
	end

	always_comb begin
		start_en = 1'b0;
		mul_en   = 1'b0;
		div_en   = 1'b0;
		post_en  = 1'b0;
		done_en  = 1'b0;
		case (state_q)
			awfc_pkg::M_IDLE: start_en = req.start;
			awfc_pkg::M_MUL:  mul_en   = 1'b1;
			awfc_pkg::M_DIV:  div_en   = 1'b1;
			awfc_pkg::M_POST: post_en  = 1'b1;
			awfc_pkg::M_DONE: done_en  = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= awfc_pkg::M_IDLE;
			phase_q <= awfc_pkg::PH_RATE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (start_en) begin
				phase_q <= awfc_pkg::PH_RATE;
				cnt_q   <= '0;
			end else if (mul_en) begin
				cnt_q <= mul_last ? '0 : cnt_q + 1'b1;
			end else if (div_en) begin
				cnt_q <= div_last ? '0 : cnt_q + 1'b1;
			end else if (post_en) begin
				cnt_q <= '0;
				case (phase_q)
					awfc_pkg::PH_RATE:   phase_q <= awfc_pkg::PH_PACKET;
					awfc_pkg::PH_PACKET: phase_q <= awfc_pkg::PH_WINDOW;
					default:             phase_q <= awfc_pkg::PH_RATE;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start_en) begin
			mcand_q   <= req.acked;
			mplier_q  <= awfc_pkg::MS_PER_SEC;
			divisor_q <= req.elapsed;
			prod_q    <= '0;
		end else if (mul_en) begin
			prod_q   <= mul_sum;
			mplier_q <= {mplier_q[TimeW-2:0], 1'b0};
			rem_q    <= '0;
		end else if (div_en) begin
			rem_q  <= rem_next;
			prod_q <= {prod_q[ProdW-2:0], rem_ge};
		end else if (post_en) begin
			case (phase_q)
				awfc_pkg::PH_RATE: begin
					rate_q    <= quo_sat;
					upd_q     <= !rate_zero;
					mcand_q   <= {{(AckW - WordW){1'b0}}, quo_sat};
					mplier_q  <= cfg_regs.flush_time_ms;
					divisor_q <= {{(WordW - TimeW){1'b0}}, awfc_pkg::MS_PER_SEC};
					prod_q    <= '0;
				end
				awfc_pkg::PH_PACKET: begin
					packet_q  <= pkt_clamp;
					mcand_q   <= {{(AckW - WordW){1'b0}}, rate_q};
					mplier_q  <= cfg_regs.window_time_ms;
					divisor_q <= {{(WordW - TimeW){1'b0}}, awfc_pkg::MS_PER_SEC};
					prod_q    <= '0;
				end
				default: begin
					window_q <= win_clamp;
				end
			endcase
		end
	end

	assign rsp.done   = done_en;
	assign rsp.upd    = upd_q;
	assign rsp.rate   = rate_q;
	assign rsp.packet = packet_q;
	assign rsp.window = window_q;

endmodule

/* sim/adaptive_window_flow_control_tb.sv */
`timescale 1ns / 1ps

module adaptive_window_flow_control_tb;
	import awfc_pkg::*;

	localparam int HalfPeriod = 5;
	localparam int ResetCycles = 7;
	// generous guard: the slowest legal run stays well below this
	localparam longint CycleLimit = 8_000_000;
	// a measuring word is the slowest, so this covers any straggler
	localparam int TailCycles = 300;
	localparam int PhaseWords = 500;
	localparam int LoopCap = 300;
	localparam logic [63:0] Max32 = 64'hFFFF_FFFF;
	localparam logic [63:0] Max40 = 64'hFF_FFFF_FFFF;
	localparam logic [AmountW-1:0] AmountMax = '1;
	localparam int RegCount = REG_FLUSH_TIME + 1;
	localparam int IdxCount = 1 << CfgIdxW;

	// one result word, field for field
	typedef struct packed {
		logic               send_enabled;
		logic               enable_changed;
		logic [PacketW-1:0] packet_bytes;
		logic [WordW-1:0]   window_bytes;
		logic [WordW-1:0]   rate_bytes_per_sec;
	} flow_status_t;

	logic clk;
	logic arst_n;

	awfc_evt_if evt_bus ();
	awfc_res_if res_bus ();
	awfc_cfg_if cfg_bus ();

	adaptive_window_flow_control i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.evt    (evt_bus),
		.res    (res_bus),
		.cfg    (cfg_bus)
	);

	// flow model: own copy of registers and counters
	cfg_regs_t          cfg_shadow;
	logic [WordW-1:0]   unacked;
	logic [AckW-1:0]    acked_sum;
	logic [WordW-1:0]   elapsed;
	logic [WordW-1:0]   ack_rate;
	logic [PacketW-1:0] packet_size;
	logic [WordW-1:0]   window_limit;
	logic               sending;

	// expected result words, oldest first
	flow_status_t status_q[$];

	// event word hand-off between test tasks and the driver
	cmd_t               next_cmd;
	logic [AmountW-1:0] next_amount;
	logic               evt_offered;
	int unsigned        evt_pushed;
	int unsigned        evt_accepted;
	int unsigned        pending_results;

	// idling knobs and the long receiver hold-off
	int unsigned src_idle_pct;
	int unsigned sink_stall_pct;
	int unsigned hold_cycles;

	// tallies
	int unsigned mismatch_cnt;
	int unsigned results_seen;
	int unsigned event_words;
	int unsigned tick_words;
	int unsigned rate_samples;
	int unsigned toggles;
	int unsigned reg_writes;
	longint      cycle_cnt;

	initial clk = 1'b0;
	always #HalfPeriod clk = ~clk;

	// ------------------------------------------------------------------
	// flow model
	// ------------------------------------------------------------------

	function automatic logic [AmountW-1:0] clamp_amount(logic [63:0] value);
		return (value > 64'(AmountMax)) ? AmountMax : value[AmountW-1:0];
	endfunction

	// rate sample, then packet and window retune from it
	function automatic void sample_ack_rate();
		logic [63:0] quot, lo, hi, pkt, win, win_floor;
		// too early: nothing changes at all
		if (elapsed < MEAS_MIN_MS)
			return;
		quot = 64'(acked_sum) * 64'(MS_PER_SEC) / 64'(elapsed);
		ack_rate = (quot > Max32) ? '1 : quot[WordW-1:0];
		acked_sum = '0;
		elapsed = '0;
		rate_samples++;
		// zero rate keeps packet and window as they are
		if (ack_rate == '0)
			return;
		lo = 64'(cfg_shadow.min_packet_kib) << KibShift;
		hi = 64'(cfg_shadow.max_packet_kib) << KibShift;
		pkt = 64'(ack_rate) * 64'(cfg_shadow.flush_time_ms) / 64'(MS_PER_SEC);
		// upper clamp first, so crossed bounds end at the lower one
		if (pkt > hi)
			pkt = hi;
		if (pkt < lo)
			pkt = lo;
		packet_size = pkt[PacketW-1:0];
		win = 64'(ack_rate) * 64'(cfg_shadow.window_time_ms) / 64'(MS_PER_SEC);
		if (win > Max32)
			win = Max32;
		win_floor = 64'(cfg_shadow.min_window_kib) << KibShift;
		if (win < win_floor)
			win = win_floor;
		window_limit = win[WordW-1:0];
	endfunction

	// advance the model by one event word and return the status it yields
	function automatic flow_status_t predict_status(cmd_t c, logic [AmountW-1:0] amt);
		logic [63:0] sum;
		logic changed;
		flow_status_t st;
		changed = 1'b0;
		case (c)
			CMD_SENT: begin
				sum = 64'(unacked) + 64'(amt);
				unacked = (sum > Max32) ? '1 : sum[WordW-1:0];
				// stop at the window, and try a rate sample right then
				if (unacked >= window_limit && sending) begin
					sending = 1'b0;
					changed = 1'b1;
					sample_ack_rate();
				end
			end
			CMD_ACKED: begin
				// acks beyond the count floor at zero
				unacked = (unacked > WordW'(amt)) ? unacked - WordW'(amt) : '0;
				sum = 64'(acked_sum) + 64'(amt);
				acked_sum = (sum > Max40) ? '1 : sum[AckW-1:0];
				// resume at half the window or below
				if (unacked <= (window_limit >> 1) && !sending) begin
					sending = 1'b1;
					changed = 1'b1;
				end
			end
			CMD_TICK: begin
				if (elapsed != '1)
					elapsed++;
			end
			default: begin
				// poll samples only after a long quiet stretch
				if (elapsed > POLL_MIN_MS)
					sample_ack_rate();
			end
		endcase
		if (changed)
			toggles++;
		st.send_enabled = sending;
		st.enable_changed = changed;
		st.packet_bytes = packet_size;
		st.window_bytes = window_limit;
		st.rate_bytes_per_sec = ack_rate;
		return st;
	endfunction

	function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
			mismatch_cnt++;
		end
	endfunction

	// ------------------------------------------------------------------
	// drivers, all changing inputs on the falling edge
	// ------------------------------------------------------------------

	// event word driver: valid stays up from offer until acceptance
	always @(negedge clk) begin
		if (!arst_n) begin
			evt_bus.valid <= 1'b0;
		end else if (!evt_offered) begin
			if (evt_pushed != evt_accepted && $urandom_range(99) >= src_idle_pct) begin
				evt_bus.valid <= 1'b1;
				evt_bus.cmd <= next_cmd;
				evt_bus.amount <= next_amount;
				evt_offered = 1'b1;
			end else begin
				evt_bus.valid <= 1'b0;
			end
		end
	end

	// receiver: long hold-off first, otherwise random stalls
	always @(negedge clk) begin
		if (!arst_n) begin
			res_bus.ready <= 1'b0;
		end else if (hold_cycles > 0) begin
			res_bus.ready <= 1'b0;
			hold_cycles--;
		end else begin
			res_bus.ready <= ($urandom_range(99) >= sink_stall_pct);
		end
	end

	// ------------------------------------------------------------------
	// scoreboard, sampled on the rising edge
	// ------------------------------------------------------------------

	always @(posedge clk) begin : score
		flow_status_t want;
		flow_status_t got;
		if (arst_n) begin
			// accepted event word: predict its status word
			if (evt_bus.valid && evt_bus.ready) begin
				status_q.push_back(predict_status(cmd_t'(evt_bus.cmd), evt_bus.amount));
				pending_results++;
				evt_accepted++;
				evt_offered = 1'b0;
			end
			// accepted result word: compare with the oldest prediction
			if (res_bus.valid && res_bus.ready) begin
				got.send_enabled = res_bus.send_enabled;
				got.enable_changed = res_bus.enable_changed;
				got.packet_bytes = res_bus.packet_bytes;
				got.window_bytes = res_bus.window_bytes;
				got.rate_bytes_per_sec = res_bus.rate_bytes_per_sec;
				results_seen++;
				if (status_q.size() == 0) begin
					$display("%0t: unexpected result word, expected none, got %p", $time, got);
					mismatch_cnt++;
				end else begin
					want = status_q.pop_front();
					pending_results--;
					check_field("send_enabled", want.send_enabled, got.send_enabled);
					check_field("enable_changed", want.enable_changed, got.enable_changed);
					check_field("packet_bytes", want.packet_bytes, got.packet_bytes);
					check_field("window_bytes", want.window_bytes, got.window_bytes);
					check_field("rate_bytes_per_sec", want.rate_bytes_per_sec,
						got.rate_bytes_per_sec);
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CycleLimit) begin
			$display("%0t: timeout after %0d cycles, %0d results outstanding", $time,
				cycle_cnt, pending_results);
			$display("DONE: errors detected");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// shared stimulus tasks
	// ------------------------------------------------------------------

	// one event word, returns once it has been accepted and predicted
	task automatic send_event(cmd_t c, logic [AmountW-1:0] amt);
		next_cmd = c;
		next_amount = amt;
		evt_pushed++;
		if (c == CMD_TICK)
			tick_words++;
		else
			event_words++;
		wait (evt_accepted == evt_pushed);
	endtask

	// sender holds back until every outstanding status word is back
	task automatic wait_drained();
		wait (evt_accepted == evt_pushed && pending_results == 0);
	endtask

	task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] value);
		@(negedge clk);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data <= value;
		do @(posedge clk); while (!cfg_bus.ready);
		reg_writes++;
		case (idx)
			REG_MIN_PACKET: cfg_shadow.min_packet_kib = value[PktKibW-1:0];
			REG_MAX_PACKET: cfg_shadow.max_packet_kib = value[PktKibW-1:0];
			REG_MIN_WINDOW: cfg_shadow.min_window_kib = value[WinKibW-1:0];
			REG_WINDOW_TIME: cfg_shadow.window_time_ms = value[TimeW-1:0];
			REG_FLUSH_TIME: cfg_shadow.flush_time_ms = value[TimeW-1:0];
			default: ; // spare index, dropped by the block
		endcase
		@(negedge clk);
		cfg_bus.valid <= 1'b0;
	endtask

	// all five registers, only with the block idle
	task automatic set_config(logic [CfgDataW-1:0] min_pkt, logic [CfgDataW-1:0] max_pkt,
		logic [CfgDataW-1:0] min_win, logic [CfgDataW-1:0] win_time,
		logic [CfgDataW-1:0] flush);
		wait_drained();
		write_reg(REG_MIN_PACKET, min_pkt);
		write_reg(REG_MAX_PACKET, max_pkt);
		write_reg(REG_MIN_WINDOW, min_win);
		write_reg(REG_WINDOW_TIME, win_time);
		write_reg(REG_FLUSH_TIME, flush);
	endtask

	// tick amounts are don't-care, so they carry random bits
	task automatic tick_burst(int n);
		repeat (n) send_event(CMD_TICK, AmountW'($urandom));
	endtask

	// enough quiet time that a poll takes a rate sample
	task automatic poll_sample();
		tick_burst(POLL_MIN_MS + 1);
		send_event(CMD_POLL, AmountW'($urandom));
	endtask

	function automatic logic [AmountW-1:0] random_amount();
		case ($urandom_range(5))
			0: return $urandom_range(1) ? AmountMax : '0;
			1: return AmountW'($urandom_range(1023));
			2: return AmountW'($urandom_range(65535));
			3: return AmountW'($urandom_range(1 << 20));
			default: return AmountW'($urandom);
		endcase
	endfunction

	// send until the window closes, landing near the boundary
	task automatic fill_window();
		logic [63:0] gap;
		int n;
		n = 0;
		while (sending && n < LoopCap) begin
			gap = (unacked >= window_limit) ? 64'd0 : 64'(window_limit) - 64'(unacked);
			case ($urandom_range(2))
				0: if (gap > 0) gap--;
				1: ;
				default: gap += $urandom_range(4095);
			endcase
			send_event(CMD_SENT, clamp_amount(gap));
			n++;
		end
	endtask

	// ack until sending comes back, often exactly at half the window
	task automatic ack_to_resume();
		logic [63:0] need;
		int n;
		n = 0;
		while (!sending && n < LoopCap) begin
			need = (unacked > (window_limit >> 1)) ?
				64'(unacked) - 64'(window_limit >> 1) : 64'd0;
			if ($urandom_range(1))
				need += $urandom_range(4095);
			send_event(CMD_ACKED, clamp_amount(need));
			n++;
		end
	endtask

	// one mixed traffic word: mostly sends and acks, some polls and noise
	task automatic random_op();
		int roll;
		roll = $urandom_range(99);
		if (roll < 40)
			send_event(CMD_SENT, random_amount());
		else if (roll < 60)
			send_event(CMD_ACKED, random_amount());
		else if (roll < 80)
			send_event(CMD_ACKED, clamp_amount(64'(unacked) >> $urandom_range(4)));
		else if (roll < 90)
			send_event(CMD_POLL, AmountW'($urandom));
		else
			send_event(cmd_t'($urandom_range(3)), AmountW'($urandom));
	endtask

	// one measurement period: ticks mixed with traffic, then a stop or a poll
	task automatic run_epoch();
		int roll, target, done, burst;
		roll = $urandom_range(99);
		if (roll < 60)
			target = $urandom_range(MEAS_MIN_MS, MEAS_MIN_MS + 200);
		else if (roll < 80)
			target = $urandom_range(POLL_MIN_MS + 1, POLL_MIN_MS + 300);
		else
			target = $urandom_range(MEAS_MIN_MS - 1);
		done = 0;
		while (done < target) begin
			burst = $urandom_range(1, 80);
			if (burst > target - done)
				burst = target - done;
			tick_burst(burst);
			done += burst;
			repeat ($urandom_range(1, 3)) random_op();
		end
		if ($urandom_range(1))
			fill_window();
		else
			send_event(CMD_POLL, AmountW'($urandom));
		ack_to_resume();
	endtask

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------

	// field extremes and every command straight out of reset
	task automatic test_reset_defaults();
		send_event(CMD_POLL, AmountMax);
		send_event(CMD_TICK, AmountMax);
		send_event(CMD_SENT, '0);
		send_event(CMD_ACKED, '0);
		// ack beyond the count floors at zero
		send_event(CMD_ACKED, 24'd1);
		send_event(CMD_SENT, 24'd1);
		// window hit with almost no time elapsed: stop, no rate sample
		send_event(CMD_SENT, AmountMax);
		send_event(CMD_SENT, AmountMax);
		send_event(CMD_POLL, '0);
		send_event(CMD_ACKED, 24'd1);
		send_event(CMD_ACKED, AmountMax);
		send_event(CMD_ACKED, AmountMax);
		send_event(CMD_TICK, '0);
	endtask

	// stop exactly at the window, resume exactly at half of it
	task automatic test_window_hysteresis();
		logic [63:0] half;
		fill_window();
		ack_to_resume();
		send_event(CMD_SENT, clamp_amount(64'(window_limit) - 64'(unacked) - 1));
		send_event(CMD_SENT, 24'd1);
		half = 64'(window_limit >> 1);
		send_event(CMD_ACKED, clamp_amount(64'(unacked) - half - 1));
		send_event(CMD_ACKED, 24'd1);
		send_event(CMD_SENT, '0);
	endtask

	// sample timing: too early, exactly 500 ms, poll at and past 2000 ms, zero rate
	task automatic test_rate_measurement();
		// elapsed restarts only with a sample, so drain any older count first
		poll_sample();
		tick_burst(MEAS_MIN_MS - 1);
		fill_window();
		ack_to_resume();
		tick_burst(1);
		send_event(CMD_ACKED, 24'd400_000);
		fill_window();
		ack_to_resume();
		tick_burst(POLL_MIN_MS);
		send_event(CMD_ACKED, 24'd900_000);
		send_event(CMD_POLL, '0);
		tick_burst(1);
		send_event(CMD_POLL, AmountMax);
		// no acks since the last sample: rate zero, packet and window held
		poll_sample();
	endtask

	// spare indexes, zero registers, crossed bounds and saturated register values
	task automatic test_config_bounds();
		wait_drained();
		for (int i = RegCount; i < IdxCount; i++)
			write_reg(CfgIdxW'(i), CfgDataW'($urandom));
		// everything zero: packet and window both collapse to zero
		set_config(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
		send_event(CMD_ACKED, 24'd3_000_000);
		poll_sample();
		// zero window stops on any send, even an empty one
		send_event(CMD_SENT, '0);
		send_event(CMD_ACKED, AmountMax);
		// crossed packet bounds with zero flush time land on the lower bound
		set_config(16'd8, 16'd2, 16'd4, 16'd3000, 16'd0);
		send_event(CMD_ACKED, 24'd5_000_000);
		poll_sample();
		// all ones, masked to register width
		set_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_event(CMD_ACKED, AmountMax);
		poll_sample();
		ack_to_resume();
	endtask

	// long receiver hold-off while the sender keeps offering words
	task automatic test_backpressure();
		wait_drained();
		src_idle_pct = 0;
		sink_stall_pct = 0;
		hold_cycles = 400;
		repeat (40) random_op();
		tick_burst(20);
		// sender pause until every status word is back
		wait_drained();
		hold_cycles = 150;
		repeat (30) random_op();
		ack_to_resume();
	endtask

	// random traffic through four idling phases and four register settings
	task automatic test_random_traffic();
		int unsigned src_tab[4];
		int unsigned sink_tab[4];
		int unsigned start;
		src_tab = '{0, 50, 0, 30};
		sink_tab = '{0, 0, 50, 30};
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: set_config(16'(MIN_PACKET_KIB_RST), 16'(MAX_PACKET_KIB_RST),
					16'(MIN_WINDOW_KIB_RST), WINDOW_TIME_RST, FLUSH_TIME_RST);
				1: set_config(16'd1, 16'd1024, 16'd1, 16'd1, 16'd60000);
				2: set_config(16'd1024, 16'd1, 16'd65535, 16'd60000, 16'd1);
				default: set_config(16'($urandom_range(1, 1024)), 16'($urandom_range(1, 1024)),
					16'($urandom_range(1, 65535)), 16'($urandom_range(1, 60000)),
					16'($urandom_range(1, 60000)));
			endcase
			src_idle_pct = src_tab[ph];
			sink_stall_pct = sink_tab[ph];
			start = event_words;
			while (event_words - start < PhaseWords)
				run_epoch();
		end
		wait_drained();
		src_idle_pct = 0;
		sink_stall_pct = 0;
	endtask

	// ack total, rate and window all saturate, then the unacked count
	task automatic test_counter_saturation();
		set_config(16'(MIN_PACKET_KIB_RST), 16'(MAX_PACKET_KIB_RST),
			16'(MIN_WINDOW_KIB_RST), 16'd60000, FLUSH_TIME_RST);
		ack_to_resume();
		// just over 2^16 full acks push the 40-bit total past its top
		repeat (65600) send_event(CMD_ACKED, AmountMax);
		tick_burst(600);
		fill_window();
		ack_to_resume();
		// with the window at all ones, only a saturated count closes it
		repeat (260) send_event(CMD_SENT, AmountMax);
		ack_to_resume();
		send_event(CMD_POLL, AmountMax);
	endtask

	// ------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------

	initial begin
		arst_n = 1'b0;
		evt_bus.valid = 1'b0;
		evt_bus.cmd = CMD_SENT;
		evt_bus.amount = '0;
		res_bus.ready = 1'b0;
		cfg_bus.valid = 1'b0;
		cfg_bus.index = REG_MIN_PACKET;
		cfg_bus.data = '0;

		// model state after reset
		cfg_shadow.min_packet_kib = MIN_PACKET_KIB_RST;
		cfg_shadow.max_packet_kib = MAX_PACKET_KIB_RST;
		cfg_shadow.min_window_kib = MIN_WINDOW_KIB_RST;
		cfg_shadow.window_time_ms = WINDOW_TIME_RST;
		cfg_shadow.flush_time_ms = FLUSH_TIME_RST;
		unacked = '0;
		acked_sum = '0;
		elapsed = '0;
		ack_rate = '0;
		packet_size = PACKET_RST;
		window_limit = WINDOW_RST;
		sending = 1'b1;

		next_cmd = CMD_SENT;
		next_amount = '0;
		evt_offered = 1'b0;
		evt_pushed = 0;
		evt_accepted = 0;
		pending_results = 0;
		src_idle_pct = 0;
		sink_stall_pct = 0;
		hold_cycles = 0;
		mismatch_cnt = 0;
		results_seen = 0;
		event_words = 0;
		tick_words = 0;
		rate_samples = 0;
		toggles = 0;
		reg_writes = 0;
		cycle_cnt = 0;

		repeat (ResetCycles) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_defaults();
		test_window_hysteresis();
		test_rate_measurement();
		test_config_bounds();
		test_backpressure();
		test_random_traffic();
		test_counter_saturation();

		// drain, then leave room for any stray word
		wait_drained();
		repeat (TailCycles) @(posedge clk);

		$display("covered %0d traffic words and %0d ticks, %0d status words checked",
			event_words, tick_words, results_seen);
		$display("with %0d rate samples, %0d stop/resume toggles, %0d register writes",
			rate_samples, toggles, reg_writes);
		if (mismatch_cnt == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
